// ----- rtl/bcpc_pkg.sv -----
// Shared types and constants for the cubic curve control point classifier.
// No dependencies; used by bcpc_cross and bezier_control_point_classifier.
package bcpc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;
    localparam int CLASS_WIDTH = 3;

    typedef enum logic [CLASS_WIDTH-1:0] {
        CLS_P2_INSIDE    = 3'd0,
        CLS_P1_INSIDE    = 3'd1,
        CLS_P1_LEFT      = 3'd2,
        CLS_P2_LEFT      = 3'd3,
        CLS_ALIGNED_1_2  = 3'd4,
        CLS_ALIGNED_2_1  = 3'd5
    } class_t;

    // sign of a cross product
    typedef struct packed {
        logic pos;
        logic neg;
    } side_t;

    // load enables of the product and sign stages
    typedef struct packed {
        logic s2;
        logic s3;
    } stage_en_t;

    function automatic side_t side_flip(side_t s);
        side_t r;
        r.pos = s.neg;
        r.neg = s.pos;
        return r;
    endfunction

endpackage

// ----- rtl/bcpc_cross.sv -----
// Two-stage cross product sign unit: registered products, then registered sign.
// Depends on bcpc_pkg.
module bcpc_cross
(
    input  logic                                  clk,
    input  bcpc_pkg::stage_en_t                   en,
    input  logic signed [bcpc_pkg::DIFF_WIDTH-1:0] ax,
    input  logic signed [bcpc_pkg::DIFF_WIDTH-1:0] ay,
    input  logic signed [bcpc_pkg::DIFF_WIDTH-1:0] bx,
    input  logic signed [bcpc_pkg::DIFF_WIDTH-1:0] by,
    output bcpc_pkg::side_t                       side
);

    logic signed [bcpc_pkg::PROD_WIDTH-1:0] prod_a_reg;
    logic signed [bcpc_pkg::PROD_WIDTH-1:0] prod_b_reg;
    logic signed [bcpc_pkg::SUM_WIDTH-1:0]  diff;
    bcpc_pkg::side_t                        side_next;
    bcpc_pkg::side_t                        side_reg;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            prod_a_reg <= ax * by;
            prod_b_reg <= bx * ay;
        end
    end

    always_comb
    begin
        diff = bcpc_pkg::SUM_WIDTH'(prod_a_reg) - bcpc_pkg::SUM_WIDTH'(prod_b_reg);
        side_next.neg = diff[bcpc_pkg::SUM_WIDTH-1];
        side_next.pos = !diff[bcpc_pkg::SUM_WIDTH-1] && (diff != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            side_reg <= side_next;
        end
    end

    assign side = side_reg;

endmodule

// ----- rtl/bezier_control_point_classifier.sv -----
// Top level of the cubic curve control point classifier.
// Depends on bcpc_pkg and bcpc_cross.
//
// Usage:
//   Input channel: in_valid / in_stall with the four control points as
//   signed coordinates, 4 fraction bits. An item is taken at a rising edge
//   with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with point_class. A result is
//   taken at a rising edge with out_valid high and out_stall low.
//   Pipeline: four register stages (edge vectors, products, signs and
//   squared distances, class). One item per cycle is sustained while
//   out_stall is low.
//   Stall: each stage moves on when the stage after it is empty or moving,
//   so bubbles close up while out_stall is high and the held result does
//   not change. in_stall rises only when all four stages hold items and
//   the output is stalled.
//   Reset: rst_n clears all valid bits; the pipeline comes up empty.
module bezier_control_point_classifier
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [bcpc_pkg::COORD_WIDTH-1:0] start_x,
    input  logic signed [bcpc_pkg::COORD_WIDTH-1:0] start_y,
    input  logic signed [bcpc_pkg::COORD_WIDTH-1:0] first_ctrl_x,
    input  logic signed [bcpc_pkg::COORD_WIDTH-1:0] first_ctrl_y,
    input  logic signed [bcpc_pkg::COORD_WIDTH-1:0] second_ctrl_x,
    input  logic signed [bcpc_pkg::COORD_WIDTH-1:0] second_ctrl_y,
    input  logic signed [bcpc_pkg::COORD_WIDTH-1:0] end_x,
    input  logic signed [bcpc_pkg::COORD_WIDTH-1:0] end_y,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic        [bcpc_pkg::CLASS_WIDTH-1:0] point_class
);

    localparam int DW = bcpc_pkg::DIFF_WIDTH;
    localparam int PW = bcpc_pkg::PROD_WIDTH;
    localparam int SW = bcpc_pkg::SUM_WIDTH;

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    bcpc_pkg::stage_en_t en;

    // stage 1: edge vectors
    logic signed [DW-1:0] u1x_reg, u1y_reg, u2x_reg, u2y_reg, u3x_reg, u3y_reg;
    logic signed [DW-1:0] d21x_reg, d21y_reg, e13x_reg, e13y_reg, e23x_reg, e23y_reg;

    // stage 2: squares and degenerate edge flags
    logic signed [PW-1:0] sq1x_reg, sq1y_reg, sq2x_reg, sq2y_reg;
    logic deg01_reg, deg02_reg, deg03_reg, deg13_reg, deg23_reg;

    // stage 3: squared distances, flags
    logic signed [SW-1:0] dist1_reg, dist2_reg;
    logic deg01_s3_reg, deg02_s3_reg, deg03_s3_reg, deg13_s3_reg, deg23_s3_reg;

    // stage 4: class
    bcpc_pkg::class_t cls_next, cls_reg;

    bcpc_pkg::side_t s01_2, s13_2, s03_2, s03_1, s23_k;
    bcpc_pkg::side_t a1, a2, a3, b1, b2, b3;
    logic in_a, in_b, near1;

    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en.s2 = en2;
    assign en.s3 = en3;

    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            u1x_reg  <= DW'(first_ctrl_x)  - DW'(start_x);
            u1y_reg  <= DW'(first_ctrl_y)  - DW'(start_y);
            u2x_reg  <= DW'(second_ctrl_x) - DW'(start_x);
            u2y_reg  <= DW'(second_ctrl_y) - DW'(start_y);
            u3x_reg  <= DW'(end_x)         - DW'(start_x);
            u3y_reg  <= DW'(end_y)         - DW'(start_y);
            d21x_reg <= DW'(second_ctrl_x) - DW'(first_ctrl_x);
            d21y_reg <= DW'(second_ctrl_y) - DW'(first_ctrl_y);
            e13x_reg <= DW'(end_x)         - DW'(first_ctrl_x);
            e13y_reg <= DW'(end_y)         - DW'(first_ctrl_y);
            e23x_reg <= DW'(end_x)         - DW'(second_ctrl_x);
            e23y_reg <= DW'(end_y)         - DW'(second_ctrl_y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            sq1x_reg  <= u1x_reg * u1x_reg;
            sq1y_reg  <= u1y_reg * u1y_reg;
            sq2x_reg  <= u2x_reg * u2x_reg;
            sq2y_reg  <= u2y_reg * u2y_reg;
            deg01_reg <= (u1x_reg == '0) && (u1y_reg == '0);
            deg02_reg <= (u2x_reg == '0) && (u2y_reg == '0);
            deg03_reg <= (u3x_reg == '0) && (u3y_reg == '0);
            deg13_reg <= (e13x_reg == '0) && (e13y_reg == '0);
            deg23_reg <= (e23x_reg == '0) && (e23y_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            dist1_reg    <= SW'(sq1x_reg) + SW'(sq1y_reg);
            dist2_reg    <= SW'(sq2x_reg) + SW'(sq2y_reg);
            deg01_s3_reg <= deg01_reg;
            deg02_s3_reg <= deg02_reg;
            deg03_s3_reg <= deg03_reg;
            deg13_s3_reg <= deg13_reg;
            deg23_s3_reg <= deg23_reg;
        end
    end

    // edge 0-1, point 2
    bcpc_cross u_x01_2
    (
        .clk  (clk),
        .en   (en),
        .ax   (u1x_reg),
        .ay   (u1y_reg),
        .bx   (u2x_reg),
        .by   (u2y_reg),
        .side (s01_2)
    );

    // edge 1-3, point 2
    bcpc_cross u_x13_2
    (
        .clk  (clk),
        .en   (en),
        .ax   (e13x_reg),
        .ay   (e13y_reg),
        .bx   (d21x_reg),
        .by   (d21y_reg),
        .side (s13_2)
    );

    // edge 0-3, point 2
    bcpc_cross u_x03_2
    (
        .clk  (clk),
        .en   (en),
        .ax   (u3x_reg),
        .ay   (u3y_reg),
        .bx   (u2x_reg),
        .by   (u2y_reg),
        .side (s03_2)
    );

    // edge 0-3, point 1
    bcpc_cross u_x03_1
    (
        .clk  (clk),
        .en   (en),
        .ax   (u3x_reg),
        .ay   (u3y_reg),
        .bx   (u1x_reg),
        .by   (u1y_reg),
        .side (s03_1)
    );

    // edge 2-3, point 1, negated
    bcpc_cross u_x23_1
    (
        .clk  (clk),
        .en   (en),
        .ax   (e23x_reg),
        .ay   (e23y_reg),
        .bx   (d21x_reg),
        .by   (d21y_reg),
        .side (s23_k)
    );

    always_comb
    begin
        // triangle 0-1-3 around point 2
        a1 = s01_2;
        a2 = s13_2;
        a3 = bcpc_pkg::side_flip(s03_2);
        // triangle 0-2-3 around point 1
        b1 = bcpc_pkg::side_flip(s01_2);
        b2 = bcpc_pkg::side_flip(s23_k);
        b3 = bcpc_pkg::side_flip(s03_1);

        in_a = !(deg01_s3_reg || deg13_s3_reg || deg03_s3_reg)
            && (!(a1.pos || a2.pos || a3.pos) || !(a1.neg || a2.neg || a3.neg));
        in_b = !(deg02_s3_reg || deg23_s3_reg || deg03_s3_reg)
            && (!(b1.pos || b2.pos || b3.pos) || !(b1.neg || b2.neg || b3.neg));
        near1 = dist1_reg < dist2_reg;

        if (in_a)
        begin
            cls_next = bcpc_pkg::CLS_P2_INSIDE;
        end
        else if (in_b)
        begin
            cls_next = bcpc_pkg::CLS_P1_INSIDE;
        end
        else if (!deg03_s3_reg && s03_1.pos && s03_2.neg)
        begin
            cls_next = bcpc_pkg::CLS_P1_LEFT;
        end
        else if (!deg03_s3_reg && s03_2.pos && s03_1.neg)
        begin
            cls_next = bcpc_pkg::CLS_P2_LEFT;
        end
        else if (near1)
        begin
            cls_next = bcpc_pkg::CLS_ALIGNED_1_2;
        end
        else
        begin
            cls_next = bcpc_pkg::CLS_ALIGNED_2_1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            cls_reg <= cls_next;
        end
    end

    assign out_valid   = v4_reg;
    assign point_class = cls_reg;

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (point_class <= bcpc_pkg::CLS_ALIGNED_2_1))
        else $error("class code out of range");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted item lost at first stage");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_valid) |=> out_valid)
        else $error("item stuck before output register");

endmodule

// ----- tb/sv/bezier_control_point_classifier_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bezier_control_point_classifier: directed and random
// control point sets, checked against an in-file class predictor.
// Depends on bcpc_pkg and the classifier RTL.
module bezier_control_point_classifier_tb;

    localparam int SIDE_UNDEF     = 2;
    localparam int RANDOM_ITEMS   = 225;
    localparam int NUM_PHASES     = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;

    typedef logic signed [bcpc_pkg::COORD_WIDTH-1:0] coord_t;

    typedef struct {
        coord_t x0, y0, x1, y1, x2, y2, x3, y3;
    } segment_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [bcpc_pkg::CLASS_WIDTH-1:0] point_class;

    segment_t         cur_seg = '{default: '0};
    segment_t         pending[$];
    bcpc_pkg::class_t class_q[$];
    bcpc_pkg::class_t want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    bezier_control_point_classifier dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_x       (cur_seg.x0),
        .start_y       (cur_seg.y0),
        .first_ctrl_x  (cur_seg.x1),
        .first_ctrl_y  (cur_seg.y1),
        .second_ctrl_x (cur_seg.x2),
        .second_ctrl_y (cur_seg.y2),
        .end_x         (cur_seg.x3),
        .end_y         (cur_seg.y3),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .point_class   (point_class)
    );

    always #10 clk = ~clk;

    // sign of the cross product of (b - a) and (p - a); undefined for a zero-length edge
    function automatic int cross_side(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by);
        longint ex, ey, cr;
        ex = bx - ax;
        ey = by - ay;
        if (ex == 0 && ey == 0)
            return SIDE_UNDEF;
        cr = ex * (py - ay) - (px - ax) * ey;
        if (cr < 0)
            return -1;
        if (cr == 0)
            return 0;
        return 1;
    endfunction

    function automatic bit in_tri(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy, longint px, longint py);
        int s1, s2, s3;
        s1 = cross_side(px, py, ax, ay, bx, by);
        s2 = cross_side(px, py, bx, by, cx, cy);
        s3 = cross_side(px, py, cx, cy, ax, ay);
        if (s1 == SIDE_UNDEF || s2 == SIDE_UNDEF || s3 == SIDE_UNDEF)
            return 1'b0;
        if (s1 <= 0 && s2 <= 0 && s3 <= 0)
            return 1'b1;
        return s1 >= 0 && s2 >= 0 && s3 >= 0;
    endfunction

    function automatic bcpc_pkg::class_t classify(segment_t s);
        longint x0, y0, x1, y1, x2, y2, x3, y3, d1, d2;
        int side1, side2;
        x0 = s.x0; y0 = s.y0;
        x1 = s.x1; y1 = s.y1;
        x2 = s.x2; y2 = s.y2;
        x3 = s.x3; y3 = s.y3;
        side1 = cross_side(x1, y1, x0, y0, x3, y3);
        side2 = cross_side(x2, y2, x0, y0, x3, y3);
        d1 = (x1 - x0) * (x1 - x0) + (y1 - y0) * (y1 - y0);
        d2 = (x2 - x0) * (x2 - x0) + (y2 - y0) * (y2 - y0);
        if (in_tri(x0, y0, x1, y1, x3, y3, x2, y2))
            return bcpc_pkg::CLS_P2_INSIDE;
        if (in_tri(x0, y0, x2, y2, x3, y3, x1, y1))
            return bcpc_pkg::CLS_P1_INSIDE;
        if (side1 == 1 && side2 == -1)
            return bcpc_pkg::CLS_P1_LEFT;
        if (side2 == 1 && side1 == -1)
            return bcpc_pkg::CLS_P2_LEFT;
        if (d1 < d2)
            return bcpc_pkg::CLS_ALIGNED_1_2;
        return bcpc_pkg::CLS_ALIGNED_2_1;
    endfunction

    function automatic segment_t mk_seg(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
        segment_t s;
        s.x0 = coord_t'(ax); s.y0 = coord_t'(ay);
        s.x1 = coord_t'(bx); s.y1 = coord_t'(by);
        s.x2 = coord_t'(cx); s.y2 = coord_t'(cy);
        s.x3 = coord_t'(dx); s.y3 = coord_t'(dy);
        return s;
    endfunction

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic segment_t rand_segment();
        segment_t s;
        int mode, cx, cy, dx, dy, k1, k2, k3;
        int ax, ay, bx, by, ex, ey, mx, my;
        mode = $urandom_range(99);
        if (mode < 30)
        begin
            s = mk_seg($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
        end
        else if (mode < 55)
        begin
            // tight cluster: coincident points, shared edges, ties
            cx = rnd(-32000, 32000);
            cy = rnd(-32000, 32000);
            s = mk_seg(cx + rnd(-3, 3), cy + rnd(-3, 3), cx + rnd(-3, 3), cy + rnd(-3, 3),
                       cx + rnd(-3, 3), cy + rnd(-3, 3), cx + rnd(-3, 3), cy + rnd(-3, 3));
        end
        else if (mode < 75)
        begin
            // points on one line through P0, P1 sometimes nudged off it by one unit in y
            cx = rnd(-2000, 2000);
            cy = rnd(-2000, 2000);
            dx = rnd(-60, 60);
            dy = rnd(-60, 60);
            k1 = rnd(-8, 8);
            k2 = rnd(-8, 8);
            k3 = rnd(-8, 8);
            s = mk_seg(cx, cy, cx + k1 * dx, cy + k1 * dy + rnd(-1, 1) * ($urandom_range(3) == 0),
                       cx + k2 * dx, cy + k2 * dy, cx + k3 * dx, cy + k3 * dy);
        end
        else
        begin
            // one control point near the centroid of the other three
            ax = rnd(-12000, 12000); ay = rnd(-12000, 12000);
            bx = rnd(-12000, 12000); by = rnd(-12000, 12000);
            ex = rnd(-12000, 12000); ey = rnd(-12000, 12000);
            mx = (ax + bx + ex) / 3 + rnd(-2, 2);
            my = (ay + by + ey) / 3 + rnd(-2, 2);
            if ($urandom_range(1))
                s = mk_seg(ax, ay, bx, by, mx, my, ex, ey);
            else
                s = mk_seg(ax, ay, mx, my, bx, by, ex, ey);
        end
        return s;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                class_q.push_back(classify(cur_seg));
            if (!in_valid || !in_stall)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_seg <= pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (class_q.size() == 0)
                begin
                    $display("%0t: class %0d with no item outstanding", $time, point_class);
                    mismatches++;
                end
                else
                begin
                    want = class_q.pop_front();
                    if (point_class !== want)
                    begin
                        $display("%0t: point_class expected %0d actual %0d",
                                 $time, want, point_class);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int idle_pct[NUM_PHASES];
        int stall_pct[NUM_PHASES];
        idle_pct  = '{0, 58, 0, 7};
        stall_pct = '{0, 0, 58, 7};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        pending.push_back(mk_seg(0, 0, 0, 0, 0, 0, 0, 0));
        pending.push_back(mk_seg(-32768, -32768, -32768, -32768,
                                 -32768, -32768, -32768, -32768));
        pending.push_back(mk_seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        pending.push_back(mk_seg(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767));
        pending.push_back(mk_seg(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
        pending.push_back(mk_seg(32767, -32768, -32768, -32768, 32767, 32767, -32768, 32767));
        pending.push_back(mk_seg(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768));
        pending.push_back(mk_seg(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                                 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA));
        // P2 inside, P1 inside
        pending.push_back(mk_seg(0, 0, 0, 160, 16, 16, 160, 0));
        pending.push_back(mk_seg(0, 0, 16, 16, 0, 160, 160, 0));
        // point on an edge
        pending.push_back(mk_seg(0, 0, 0, 160, 80, 0, 160, 0));
        pending.push_back(mk_seg(0, 0, 0, 80, 0, 160, 160, 0));
        // opposite sides, both orders
        pending.push_back(mk_seg(0, 0, 80, 160, 80, -160, 160, 0));
        pending.push_back(mk_seg(0, 0, 80, -160, 80, 160, 160, 0));
        // zero-length P0-P3
        pending.push_back(mk_seg(0, 0, 16, 0, 0, 32, 0, 0));
        pending.push_back(mk_seg(0, 0, 48, 0, 0, 32, 0, 0));
        pending.push_back(mk_seg(0, 0, 16, 0, 0, 16, 0, 0));
        // zero-length P0-P1 and P1-P3
        pending.push_back(mk_seg(0, 0, 0, 0, 32, 32, 160, 0));
        pending.push_back(mk_seg(0, 0, 160, 0, 32, 32, 160, 0));
        // same side, P1 inside, then P2 inside
        pending.push_back(mk_seg(0, 0, 16, 16, 144, 320, 160, 0));
        pending.push_back(mk_seg(0, 0, 144, 320, 16, 16, 160, 0));
        // collinear on a proper line
        pending.push_back(mk_seg(0, 0, 32, 0, 48, 0, 16, 0));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct <= idle_pct[ph];
            recv_stall_pct <= stall_pct[ph];
            for (int i = 0; i < RANDOM_ITEMS; i++)
                pending.push_back(rand_segment());
            while (pending.size() != 0 || in_valid || class_q.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (class_q.size() != 0)
        begin
            $display("%0t: %0d expected classes never arrived", $time, class_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
